[design/nonblocking_icache_miss_coalescing_core_macros.svh]
// Assertion macros for the icache miss coalescing RTL.
`ifndef NONBLOCKING_ICACHE_MISS_COALESCING_CORE_MACROS_SVH
`define NONBLOCKING_ICACHE_MISS_COALESCING_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ICMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ICMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICMC_ASSERT_NOW(lbl, ante, cons, msg)
`define ICMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/icmc_pkg.sv]
// Shared types and codes for the icache miss coalescing core.
package icmc_pkg;

    localparam int ADDR_W = 48;
    localparam int CRED_W = 8;

    localparam logic [1:0] CMD_FETCH  = 2'd0;
    localparam logic [1:0] CMD_CREDIT = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_L2    = 1'b1;

    typedef struct packed {
        logic accept;
        logic tick_fill;
        logic fill_update;
        logic sweep_step;
        logic take_replay;
        logic take_fetch_hit;
        logic fetch_rd;
        logic lookup;
        logic emit_resp;
        logic emit_l2;
        logic last;
    } icmc_cmd_t;

    typedef struct packed {
        logic fill_empty;
        logic replay_empty;
        logic fetch_empty;
        logic sweep_done;
        logic send_ok;
        logic out_free;
        logic always_hit;
    } icmc_stat_t;

endpackage

[design/icmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module icmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/icmc_fifo.sv]
// Small flop FIFO; a push into a full FIFO is dropped.
module icmc_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    wr_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             full;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

[design/icmc_datapath.sv]
// Datapath: queues, tag/LRU rows, valid bits, pending buffer, credits, output register.
module icmc_datapath #(
    parameter int NUM_SETS    = 64,
    parameter int NUM_WAYS    = 8,
    parameter int LINE_BYTES  = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  icmc_pkg::icmc_cmd_t        cmd,
    output icmc_pkg::icmc_stat_t       stat,
    input  logic [1:0]                 s_cmd,
    input  logic [47:0]                s_address,
    input  logic [7:0]                 s_credit_count,
    input  logic                       s_fill_hit,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_kind,
    output logic [47:0]                m_out_address,
    output logic                       m_hit,
    output logic                       m_replayed,
    output logic                       m_fetch_credit,
    output logic                       m_last
);
    import icmc_pkg::*;

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int SETB  = $clog2(NUM_SETS);
    localparam int SET_W = (SETB > 0) ? SETB : 1;
    localparam int BLK_W = ADDR_W - OFF_W;
    localparam int TAG_W = BLK_W - SETB;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int TAGS_W = NUM_WAYS * TAG_W;
    localparam int LRU_TOP = TAGS_W + NUM_WAYS * WAY_W;
    localparam int ROW_W = NUM_WAYS * (TAG_W + WAY_W + 1);
    localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_WAYS-1:0][WAY_W-1:0] lru_t;
    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tags_t;

    function automatic logic [BLK_W-1:0] blk_of(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:OFF_W];
    endfunction

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
        logic [BLK_W-1:0] b;
        b = a[ADDR_W-1:OFF_W];
        return SET_W'(b % BLK_W'(NUM_SETS));
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
        logic [BLK_W-1:0] b;
        b = a[ADDR_W-1:OFF_W];
        return TAG_W'(b / BLK_W'(NUM_SETS));
    endfunction

    function automatic lru_t lru_identity();
        lru_t n;
        for (int p = 0; p < NUM_WAYS; p++) begin
            n[p] = WAY_W'(p);
        end
        return n;
    endfunction

    // Move way w to the front, shifting everything up to its old place back by one.
    function automatic lru_t lru_touch(input lru_t o, input logic [WAY_W-1:0] w);
        lru_t n;
        logic seen;
        n    = o;
        seen = 1'b0;
        for (int p = 0; p < NUM_WAYS; p++) begin
            if (p > 0 && !seen) begin
                n[p] = o[(p > 0) ? p - 1 : 0];
            end
            if (o[p] == w) begin
                seen = 1'b1;
            end
        end
        n[0] = w;
        return n;
    endfunction

    // Queues
    logic [ADDR_W-1:0] fetch_dout, fill_dout, replay_dout, l2_dout, pend_din;
    logic fetch_empty, fill_empty, replay_empty, l2_empty;
    logic fetch_push, fill_push, replay_push, l2_push, fetch_pop;

    assign fetch_push = cmd.accept && (s_cmd == CMD_FETCH);
    assign fill_push  = cmd.accept && (s_cmd == CMD_FILL) && s_fill_hit;
    assign fetch_pop  = cmd.take_fetch_hit || cmd.fetch_rd;

    icmc_fifo #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_fetch_q (
        .aclk(aclk), .aresetn(aresetn), .push(fetch_push), .din(s_address),
        .pop(fetch_pop), .dout(fetch_dout), .empty(fetch_empty)
    );
    icmc_fifo #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_fill_q (
        .aclk(aclk), .aresetn(aresetn), .push(fill_push), .din(s_address),
        .pop(cmd.tick_fill), .dout(fill_dout), .empty(fill_empty)
    );
    icmc_fifo #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_replay_q (
        .aclk(aclk), .aresetn(aresetn), .push(replay_push), .din(pend_din),
        .pop(cmd.take_replay), .dout(replay_dout), .empty(replay_empty)
    );

    // Tag, LRU and valid rows
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;

    icmc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [ADDR_W-1:0]   wk_addr_reg;
    // A row never written since reset reads as all ways invalid, LRU in index order
    logic [NUM_SETS-1:0] lru_ok_reg;
    logic [ADDR_W-1:0]   pend_reg [QUEUE_DEPTH];
    logic [QC_W-1:0]     pcnt_reg, idx_reg, keep_reg;
    logic [CRED_W-1:0]   credits_reg;
    logic                always_hit_reg;
    logic [ADDR_W-1:0]   resp_addr_reg;
    logic                resp_hit_reg, resp_rep_reg, resp_cred_reg;

    logic [SET_W-1:0]    wk_set;
    logic [TAG_W-1:0]    wk_tag;
    logic [NUM_WAYS-1:0] wk_valid, new_valid;
    tags_t               rd_tags, new_tags;
    lru_t                cur_lru, new_lru;
    logic [WAY_W-1:0]    victim, hit_way, touch_way;
    logic                any_invalid, tag_hit, found;
    logic                sweep_live, sweep_match;

    assign ram_raddr = cmd.tick_fill ? set_of(fill_dout) : set_of(fetch_dout);
    assign wk_set    = set_of(wk_addr_reg);
    assign wk_tag    = tag_of(wk_addr_reg);
    assign wk_valid  = lru_ok_reg[wk_set] ? ram_rdata[ROW_W-1:LRU_TOP] : '0;
    assign rd_tags   = ram_rdata[TAGS_W-1:0];
    assign cur_lru   = lru_ok_reg[wk_set] ? lru_t'(ram_rdata[LRU_TOP-1:TAGS_W])
                                          : lru_identity();

    always_comb begin
        victim      = cur_lru[NUM_WAYS-1];
        any_invalid = 1'b0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!wk_valid[w]) begin
                victim      = WAY_W'(w);
                any_invalid = 1'b1;
            end
        end
        tag_hit = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (wk_valid[w] && rd_tags[w] == wk_tag) begin
                tag_hit = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        found = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (QC_W'(i) < pcnt_reg && blk_of(pend_reg[i]) == blk_of(wk_addr_reg)) begin
                found = 1'b1;
            end
        end
    end

    assign touch_way = cmd.fill_update ? victim : hit_way;
    assign new_lru   = lru_touch(cur_lru, touch_way);

    always_comb begin
        new_tags  = rd_tags;
        new_valid = wk_valid;
        if (cmd.fill_update) begin
            new_tags[victim]  = wk_tag;
            new_valid[victim] = 1'b1;
        end
    end

    assign ram_we    = cmd.fill_update || (cmd.lookup && tag_hit);
    assign ram_waddr = wk_set;
    assign ram_wdata = {new_valid, new_lru, new_tags};

    // Pending-buffer sweep after a fill: matching entries go to replay, the rest close up.
    assign sweep_live  = cmd.sweep_step && (idx_reg != pcnt_reg);
    assign pend_din    = pend_reg[idx_reg[QP_W-1:0]];
    assign sweep_match = blk_of(pend_din) == blk_of(wk_addr_reg);
    assign replay_push = sweep_live && sweep_match;

    assign l2_push = cmd.lookup && !tag_hit && !found;

    icmc_fifo #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_l2_q (
        .aclk(aclk), .aresetn(aresetn), .push(l2_push), .din(wk_addr_reg),
        .pop(cmd.emit_l2), .dout(l2_dout), .empty(l2_empty)
    );

    logic [CRED_W:0] cred_sum;
    assign cred_sum = {1'b0, credits_reg} + {1'b0, s_credit_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lru_ok_reg     <= '0;
            pcnt_reg       <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            credits_reg    <= '0;
            always_hit_reg <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            if (cfg_we) begin
                always_hit_reg <= cfg_wdata;
            end
            if (cmd.accept && s_cmd == CMD_CREDIT) begin
                credits_reg <= cred_sum[CRED_W] ? {CRED_W{1'b1}} : cred_sum[CRED_W-1:0];
            end else if (cmd.emit_l2) begin
                credits_reg <= credits_reg - 1'b1;
            end
            if (cmd.fill_update) begin
                idx_reg  <= '0;
                keep_reg <= '0;
            end
            if (ram_we) begin
                lru_ok_reg[wk_set] <= 1'b1;
            end
            if (sweep_live) begin
                idx_reg <= idx_reg + 1'b1;
                if (!sweep_match) begin
                    keep_reg <= keep_reg + 1'b1;
                end
            end else if (cmd.sweep_step) begin
                pcnt_reg <= keep_reg;
            end
            if (cmd.lookup && !tag_hit && pcnt_reg != QC_W'(QUEUE_DEPTH)) begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
            if (cmd.emit_resp || cmd.emit_l2) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_fill) begin
            wk_addr_reg <= fill_dout;
        end else if (cmd.fetch_rd) begin
            wk_addr_reg <= fetch_dout;
        end
        if (sweep_live && !sweep_match) begin
            pend_reg[keep_reg[QP_W-1:0]] <= pend_din;
        end
        if (cmd.lookup && !tag_hit && pcnt_reg != QC_W'(QUEUE_DEPTH)) begin
            pend_reg[pcnt_reg[QP_W-1:0]] <= wk_addr_reg;
        end
        if (cmd.take_replay) begin
            resp_addr_reg <= replay_dout;
            resp_hit_reg  <= 1'b1;
            resp_rep_reg  <= 1'b1;
            resp_cred_reg <= 1'b1;
        end else if (cmd.take_fetch_hit) begin
            resp_addr_reg <= fetch_dout;
            resp_hit_reg  <= 1'b1;
            resp_rep_reg  <= 1'b0;
            resp_cred_reg <= 1'b1;
        end else if (cmd.lookup) begin
            resp_addr_reg <= wk_addr_reg;
            resp_hit_reg  <= tag_hit;
            resp_rep_reg  <= 1'b0;
            resp_cred_reg <= tag_hit;
        end
        if (cmd.emit_resp) begin
            m_kind         <= KIND_FETCH;
            m_out_address  <= resp_addr_reg;
            m_hit          <= resp_hit_reg;
            m_replayed     <= resp_rep_reg;
            m_fetch_credit <= resp_cred_reg;
            m_last         <= cmd.last;
        end else if (cmd.emit_l2) begin
            m_kind         <= KIND_L2;
            m_out_address  <= l2_dout;
            m_hit          <= 1'b0;
            m_replayed     <= 1'b0;
            m_fetch_credit <= 1'b0;
            m_last         <= cmd.last;
        end
    end

    assign stat.fill_empty   = fill_empty;
    assign stat.replay_empty = replay_empty;
    assign stat.fetch_empty  = fetch_empty;
    assign stat.sweep_done   = (idx_reg == pcnt_reg);
    assign stat.send_ok      = (credits_reg != '0) && !l2_empty;
    assign stat.out_free     = !m_valid || m_ready;
    assign stat.always_hit   = always_hit_reg;
endmodule

[design/icmc_ctrl.sv]
// Controller: sequences one input item through fill, sweep, lookup and send steps.
`include "nonblocking_icache_miss_coalescing_core_macros.svh"
module icmc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_cmd,
    output logic                 s_ready,
    input  icmc_pkg::icmc_stat_t stat,
    output icmc_pkg::icmc_cmd_t  cmd
);
    import icmc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_SERVE = 3'd4;
    localparam logic [2:0] ST_LOOK  = 3'd5;
    localparam logic [2:0] ST_SEND  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       resp_pend_reg, resp_pend_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        resp_pend_next = resp_pend_reg;
        cmd.accept     = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_TICK) begin
                        state_next = ST_TICK;
                    end else if (s_cmd == CMD_CREDIT) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_TICK: begin
                if (!stat.fill_empty) begin
                    cmd.tick_fill = 1'b1;
                    state_next    = ST_FILL;
                end else begin
                    state_next = ST_SERVE;
                end
            end
            ST_FILL: begin
                cmd.fill_update = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE: begin
                state_next = ST_SEND;
                if (!stat.replay_empty) begin
                    cmd.take_replay = 1'b1;
                    resp_pend_next  = 1'b1;
                end else if (!stat.fetch_empty) begin
                    if (stat.always_hit) begin
                        cmd.take_fetch_hit = 1'b1;
                        resp_pend_next     = 1'b1;
                    end else begin
                        cmd.fetch_rd = 1'b1;
                        state_next   = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                cmd.lookup     = 1'b1;
                resp_pend_next = 1'b1;
                state_next     = ST_SEND;
            end
            ST_SEND: begin
                // Hold until the output register frees; the response goes before the L2 request.
                if (resp_pend_reg) begin
                    if (stat.out_free) begin
                        cmd.emit_resp  = 1'b1;
                        cmd.last       = !stat.send_ok;
                        resp_pend_next = 1'b0;
                        if (!stat.send_ok) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (stat.send_ok) begin
                    if (stat.out_free) begin
                        cmd.emit_l2 = 1'b1;
                        cmd.last    = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            resp_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            resp_pend_reg <= resp_pend_next;
        end
    end

    `ICMC_ASSERT_NOW(a_single_emit, 1'b1, !(cmd.emit_resp && cmd.emit_l2), "two results in one cycle")
    `ICMC_ASSERT_NOW(a_emit_free, (cmd.emit_resp || cmd.emit_l2), stat.out_free, "output overrun")
    `ICMC_ASSERT_NOW(a_l2_credit, cmd.emit_l2, stat.send_ok, "L2 request without credit")
    `ICMC_ASSERT_NEXT(a_look_resp, (state_reg == ST_LOOK), resp_pend_reg, "lookup lost its response")
endmodule

[design/nonblocking_icache_miss_coalescing_core.sv]
// Top level of the non-blocking icache front end with miss coalescing.
// Input channel s_*: one item per handshake carrying a command (fetch request,
// L2 credit grant, L2 fill response or arbitration tick) with its address,
// credit count and fill status. Fetch and fill items only queue; a fill
// without s_fill_hit is dropped. A credit grant may send one L2 request.
// A tick, when a fill is queued, installs it and sweeps the pending buffer,
// then serves a replay or a fetch (with a tag lookup unless always_hit is set)
// and sends any fetch response and, with credit, one L2 request;
// one item is worked on at a time, the tag/LRU row RAM and the sweep set this.
// Result channel m_*: up to two results per tick (fetch response, then L2
// request), the final one flagged by m_last, out of one output register.
// A stalled receiver holds the block in its send step; items already queued
// are kept. Reset empties all queues and the pending buffer, clears valid bits,
// credits and always_hit, and restores the LRU order of every set to way index
// order; no clearing pass runs. cfg_we writes always_hit from cfg_wdata.
module nonblocking_icache_miss_coalescing_core #(
    parameter int NUM_SETS    = 64,
    parameter int NUM_WAYS    = 8,
    parameter int LINE_BYTES  = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [47:0] s_address,
    input  logic [7:0]  s_credit_count,
    input  logic        s_fill_hit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [47:0] m_out_address,
    output logic        m_hit,
    output logic        m_replayed,
    output logic        m_fetch_credit,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import icmc_pkg::*;

    icmc_cmd_t  cmd;
    icmc_stat_t stat;

    icmc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_cmd(s_cmd),
        .s_ready(s_ready), .stat(stat), .cmd(cmd)
    );

    icmc_datapath #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
        .LINE_BYTES(LINE_BYTES), .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_cmd(s_cmd), .s_address(s_address), .s_credit_count(s_credit_count),
        .s_fill_hit(s_fill_hit), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_out_address(m_out_address), .m_hit(m_hit), .m_replayed(m_replayed),
        .m_fetch_credit(m_fetch_credit), .m_last(m_last)
    );
endmodule

[tb/nonblocking_icache_miss_coalescing_core_test.sv]
// Self-checking testbench for the non-blocking icache miss coalescing core.
`timescale 1ns / 1ps

module nonblocking_icache_miss_coalescing_core_test;
    import icmc_pkg::*;

    localparam int SETS = 64;
    localparam int WAYS = 8;
    localparam int QDEPTH = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int LONG_HOLD_AT = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        logic [1:0]  cmd;
        logic [47:0] addr;
        logic [7:0]  credits;
        logic        fill_hit;
    } fe_item_t;

    typedef struct {
        logic        kind;
        logic [47:0] addr;
        logic        hit;
        logic        replayed;
        logic        fetch_credit;
        logic        last;
    } fe_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_TICK;
    logic [47:0] s_address = '0;
    logic [7:0]  s_credit_count = '0;
    logic        s_fill_hit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [47:0] m_out_address;
    logic        m_hit;
    logic        m_replayed;
    logic        m_fetch_credit;
    logic        m_last;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    nonblocking_icache_miss_coalescing_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_address(s_address),
        .s_credit_count(s_credit_count), .s_fill_hit(s_fill_hit),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_out_address(m_out_address), .m_hit(m_hit), .m_replayed(m_replayed),
        .m_fetch_credit(m_fetch_credit), .m_last(m_last),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow cache state
    logic [35:0] tag_mem [SETS][WAYS];
    bit          way_valid [SETS][WAYS];
    int unsigned lru_rank [SETS][WAYS];
    logic [47:0] fetch_q[$], fill_q[$], replay_q[$], l2_req_q[$], miss_buf[$];
    int unsigned l2_credit_cnt;
    bit          hit_forced;

    fe_item_t    pending_items[$];
    fe_result_t  expected_results[$];
    fe_item_t    cur_item;
    int          send_gap;
    bit          no_idle;
    int          results_seen;
    int          recv_stall;
    int          long_hold;
    bit          long_hold_done;
    int          quiet_cycles;
    bit          failed;
    logic [35:0] pool_tags [12];
    logic [5:0]  pool_sets [2];

    function automatic logic [5:0] set_of(logic [47:0] a);
        return a[11:6];
    endfunction

    function automatic void make_mru(int s, int unsigned w);
        int p;
        p = 0;
        while (p < WAYS && lru_rank[s][p] != w) p++;
        if (p >= WAYS) p = WAYS - 1;
        for (int i = p; i > 0; i--) lru_rank[s][i] = lru_rank[s][i - 1];
        lru_rank[s][0] = w;
    endfunction

    function automatic void push_result(logic kind, logic [47:0] a, logic h, logic r, logic c);
        fe_result_t res;
        res.kind = kind;
        res.addr = a;
        res.hit = h;
        res.replayed = r;
        res.fetch_credit = c;
        res.last = 1'b0;
        expected_results = {expected_results, res};
    endfunction

    function automatic bit try_l2_send();
        logic [47:0] a;
        if (l2_credit_cnt > 0 && l2_req_q.size() > 0) begin
            a = l2_req_q[0];
            l2_req_q.delete(0);
            push_result(KIND_L2, a, 1'b0, 1'b0, 1'b0);
            l2_credit_cnt--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void install_line(logic [47:0] a);
        int s;
        int unsigned w;
        logic [47:0] kept[$];
        s = set_of(a);
        w = lru_rank[s][WAYS - 1];
        for (int i = WAYS - 1; i >= 0; i--) if (!way_valid[s][i]) w = i;
        tag_mem[s][w] = a[47:12];
        way_valid[s][w] = 1'b1;
        make_mru(s, w);
        foreach (miss_buf[i]) begin
            if (miss_buf[i][47:6] == a[47:6]) begin
                if (replay_q.size() < QDEPTH) replay_q = {replay_q, miss_buf[i]};
            end else begin
                kept = {kept, miss_buf[i]};
            end
        end
        miss_buf = kept;
    endfunction

    function automatic bit tag_lookup(logic [47:0] a);
        int s;
        s = set_of(a);
        if (hit_forced) return 1'b1;
        for (int w = 0; w < WAYS; w++) begin
            if (way_valid[s][w] && tag_mem[s][w] == a[47:12]) begin
                make_mru(s, w);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the results one accepted item causes
    function automatic void cache_step(fe_item_t it);
        int prior_count;
        bit h, known;
        logic [47:0] a;
        prior_count = expected_results.size();
        case (it.cmd)
            CMD_FETCH: if (fetch_q.size() < QDEPTH) fetch_q = {fetch_q, it.addr};
            CMD_CREDIT: begin
                l2_credit_cnt += it.credits;
                if (l2_credit_cnt > 255) l2_credit_cnt = 255;
                void'(try_l2_send());
            end
            CMD_FILL: if (it.fill_hit && fill_q.size() < QDEPTH) fill_q = {fill_q, it.addr};
            default: begin
                if (fill_q.size() > 0) begin
                    a = fill_q[0];
                    fill_q.delete(0);
                    install_line(a);
                end
                if (replay_q.size() > 0) begin
                    a = replay_q[0];
                    replay_q.delete(0);
                    push_result(KIND_FETCH, a, 1'b1, 1'b1, 1'b1);
                end else if (fetch_q.size() > 0) begin
                    a = fetch_q[0];
                    fetch_q.delete(0);
                    h = tag_lookup(a);
                    if (!h) begin
                        known = 1'b0;
                        foreach (miss_buf[i]) if (miss_buf[i][47:6] == a[47:6]) known = 1'b1;
                        if (!known && l2_req_q.size() < QDEPTH) l2_req_q = {l2_req_q, a};
                        if (miss_buf.size() < QDEPTH) miss_buf = {miss_buf, a};
                    end
                    push_result(KIND_FETCH, a, h, 1'b0, h);
                end
                void'(try_l2_send());
            end
        endcase
        if (expected_results.size() > prior_count)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_item(logic [1:0] c, logic [47:0] a, logic [7:0] cc, logic fh);
        fe_item_t it;
        it.cmd = c;
        it.addr = a;
        it.credits = cc;
        it.fill_hit = fh;
        pending_items = {pending_items, it};
    endfunction

    function automatic logic [47:0] pool_addr();
        return {pool_tags[$urandom_range(0, 11)], pool_sets[$urandom_range(0, 1)],
                6'($urandom)};
    endfunction

    function automatic logic [47:0] any_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly traffic on a few crowded sets, with some noise across the address space
    function automatic void add_random_item();
        int pick;
        logic [47:0] a;
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? any_addr() : pool_addr();
        if (pick < 30)
            add_item(CMD_FETCH, a, 8'($urandom), 1'($urandom));
        else if (pick < 45)
            add_item(CMD_FILL, a, 8'($urandom), $urandom_range(0, 7) != 0);
        else if (pick < 55)
            add_item(CMD_CREDIT, a,
                     ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                     1'($urandom));
        else
            add_item(CMD_TICK, a, 8'($urandom), 1'($urandom));
    endfunction

    // Sender
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) cache_step(cur_item);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items[0];
                    pending_items.delete(0);
                    s_valid <= 1'b1;
                    s_cmd <= cur_item.cmd;
                    s_address <= cur_item.addr;
                    s_credit_count <= cur_item.credits;
                    s_fill_hit <= cur_item.fill_hit;
                    if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 5);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Hold off once for a long stretch so the block backs up
    always @(posedge aclk) begin
        if (aresetn) begin
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold <= LONG_HOLD;
                long_hold_done <= 1'b1;
            end
        end
    end

    // Receiver and checker
    always @(posedge aclk) begin
        fe_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: address %h", m_out_address);
                    failed = 1'b1;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        failed = 1'b1;
                    end
                    if (m_out_address !== want.addr) begin
                        $error("out_address: expected %h, got %h", want.addr, m_out_address);
                        failed = 1'b1;
                    end
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_hit);
                        failed = 1'b1;
                    end
                    if (m_replayed !== want.replayed) begin
                        $error("replayed: expected %0d, got %0d", want.replayed, m_replayed);
                        failed = 1'b1;
                    end
                    if (m_fetch_credit !== want.fetch_credit) begin
                        $error("fetch_credit: expected %0d, got %0d",
                               want.fetch_credit, m_fetch_credit);
                        failed = 1'b1;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        failed = 1'b1;
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (long_hold > 0) begin
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("nonblocking_icache_miss_coalescing_core regression: fail");
            $finish;
        end
    end

    task automatic drain_and_settle();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_always_hit(logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        hit_forced = v;
    endtask

    initial begin
        logic [47:0] a;
        int burst;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                way_valid[s][w] = 1'b0;
                lru_rank[s][w] = w;
            end
        l2_credit_cnt = 0;
        hit_forced = 1'b0;
        foreach (pool_tags[i]) pool_tags[i] = {4'($urandom), 32'($urandom)};
        pool_sets[0] = 6'($urandom);
        pool_sets[1] = 6'($urandom);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_always_hit(1'b0);

        // Directed: idle tick, ignored fill, extremes, full fetch queue,
        // coalesced misses and their replay, credit saturation
        add_item(CMD_TICK, '0, '0, 1'b0);
        add_item(CMD_FILL, '1, 8'hff, 1'b0);
        add_item(CMD_FETCH, '0, '0, 1'b0);
        add_item(CMD_FETCH, 48'h0000_0000_0010, '0, 1'b0);
        add_item(CMD_FETCH, '1, 8'hff, 1'b1);
        for (int i = 0; i < 6; i++) add_item(CMD_FETCH, {42'h2aa_aaaa_aaaa, 6'(i)}, '0, 1'b0);
        for (int i = 0; i < 4; i++) add_item(CMD_TICK, '0, '0, 1'b0);
        add_item(CMD_CREDIT, '0, 8'd0, 1'b0);
        add_item(CMD_CREDIT, '0, 8'hff, 1'b0);
        add_item(CMD_CREDIT, '0, 8'hff, 1'b0);
        add_item(CMD_FILL, 48'h0000_0000_0020, '0, 1'b1);
        for (int i = 0; i < 5; i++) add_item(CMD_TICK, '1, '0, 1'b0);
        add_item(CMD_FILL, '1, '0, 1'b1);
        add_item(CMD_TICK, '0, '0, 1'b0);
        add_item(CMD_TICK, '0, '0, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    // misses to one block, a fill for it, then ticks to replay them
                    a = pool_addr();
                    burst = $urandom_range(2, 9);
                    for (int k = 0; k < burst; k++)
                        add_item(CMD_FETCH, {a[47:6], 6'($urandom)}, '0, 1'b0);
                    repeat ($urandom_range(2, 9)) add_item(CMD_TICK, any_addr(), '0, 1'b0);
                    add_item(CMD_CREDIT, '0, 8'($urandom_range(1, 4)), 1'b0);
                    add_item(CMD_FILL, a, '0, 1'b1);
                    repeat ($urandom_range(3, 10)) add_item(CMD_TICK, any_addr(), '0, 1'b0);
                end else begin
                    add_random_item();
                end
            end
            drain_and_settle();
            write_always_hit(phase[0] == 1'b0);
        end
        drain_and_settle();

        if (!failed)
            $display("nonblocking_icache_miss_coalescing_core regression: pass");
        else
            $display("nonblocking_icache_miss_coalescing_core regression: fail");
        $finish;
    end

endmodule

[nonblocking_icache_miss_coalescing_core.f]
+incdir+design
design/icmc_pkg.sv
design/icmc_ram.sv
design/icmc_fifo.sv
design/icmc_datapath.sv
design/icmc_ctrl.sv
design/nonblocking_icache_miss_coalescing_core.sv
tb/nonblocking_icache_miss_coalescing_core_test.sv
